/* sv/dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions of the double-ended queue
// Command codes and default sizes used by the interfaces and the modules.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 8;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} dq_cmd_t;

endpackage

/* sv/dq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_if: command and result channels of the double-ended queue
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface dq_cmd_if #(
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
);
	import dq_pkg::*;

	logic                  valid;
	logic                  ready;
	dq_cmd_t               cmd;
	logic [DATA_WIDTH-1:0] push_byte;

	modport source (output valid, output cmd, output push_byte, input ready);
	modport sink   (input valid, input cmd, input push_byte, output ready);
endinterface

interface dq_res_if #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] popped_byte;
	logic                  op_error;
	logic [CW-1:0]         entry_count;
	logic [DATA_WIDTH-1:0] front_byte;
	logic [DATA_WIDTH-1:0] rear_byte;
	logic                  now_empty;

	modport source (output valid, output popped_byte, output op_error, output entry_count,
		output front_byte, output rear_byte, output now_empty, input ready);
	modport sink   (input valid, input popped_byte, input op_error, input entry_count,
		input front_byte, input rear_byte, input now_empty, output ready);
endinterface

/* sv/dq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram: slot storage of the double-ended queue
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0]    wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0]    rd_data
);
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read data holds until the next read, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

/* sv/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a circular slot memory
// Push and pop at either end with one result per command.
// ----------------------------------------------------------------------------
// Each command transaction produces exactly one result transaction carrying the
// popped byte, an error flag, the count after the command, the front and rear
// bytes after the command (zero when empty) and an empty flag. A pop from an
// empty deque or a push to a full one leaves the contents unchanged and raises
// op_error. The front and rear bytes are kept in registers; a pop that exposes
// a new end fetches it from the slot memory through its registered read port.
// A taken command waits in stage 1 until its result, with the fetched byte
// merged in, moves into the output register; only then is the next command
// taken. The output register lets one finished result wait for the consumer
// while the next command is taken; a second result then waits until the
// first transaction completes. No clearing pass is needed after reset: only
// slots holding live entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	dq_cmd_if.sink   cmd_ch,
	dq_res_if.source res_ch
);
	import dq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Pointer and count state. The head points at the front entry, the tail
	// just past the rear entry.
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [DATA_WIDTH-1:0] front_q, rear_q;

	// Stage 1 holds a command whose result is being formed.
	logic                  busy_s1;
	logic [DATA_WIDTH-1:0] popped_s1;
	logic                  err_s1;
	logic                  rd_front_s1;
	logic                  rd_rear_s1;

	// Output register.
	logic                  res_valid_q;
	logic [DATA_WIDTH-1:0] res_popped_q, res_front_q, res_rear_q;
	logic                  res_err_q, res_empty_q;
	logic [CW-1:0]         res_count_q;

	logic accept, done;
	logic full, empty;
	logic [PW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_dec2;

	// Next-state decode of the command being accepted.
	logic [PW-1:0]         head_n, tail_n;
	logic [CW-1:0]         count_n;
	logic                  wr_en, rd_en;
	logic [PW-1:0]         wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] front_n, rear_n;
	logic [DATA_WIDTH-1:0] popped_n;
	logic                  err_n, rd_front_n, rd_rear_n;

	logic [DATA_WIDTH-1:0] rd_data;
	logic [DATA_WIDTH-1:0] front_fin, rear_fin;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
	endfunction

	assign cmd_ch.ready = !busy_s1;
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign done         = busy_s1 && (!res_valid_q || res_ch.ready);

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_inc  = ptr_inc(head_q);
	assign head_dec  = ptr_dec(head_q);
	assign tail_inc  = ptr_inc(tail_q);
	assign tail_dec  = ptr_dec(tail_q);
	assign tail_dec2 = ptr_dec(tail_dec);

	always_comb begin
		head_n     = head_q;
		tail_n     = tail_q;
		count_n    = count_q;
		wr_en      = 1'b0;
		wr_addr    = tail_q;
		rd_en      = 1'b0;
		rd_addr    = head_inc;
		front_n    = front_q;
		rear_n     = rear_q;
		popped_n   = '0;
		err_n      = 1'b0;
		rd_front_n = 1'b0;
		rd_rear_n  = 1'b0;
		unique case (cmd_ch.cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					err_n = 1'b1;
				end else begin
					head_n  = head_dec;
					count_n = count_q + CW'(1);
					wr_en   = 1'b1;
					wr_addr = head_dec;
					front_n = cmd_ch.push_byte;
					if (empty) begin
						rear_n = cmd_ch.push_byte;
					end
				end
			end
			CMD_PUSH_REAR: begin
				if (full) begin
					err_n = 1'b1;
				end else begin
					tail_n  = tail_inc;
					count_n = count_q + CW'(1);
					wr_en   = 1'b1;
					wr_addr = tail_q;
					rear_n  = cmd_ch.push_byte;
					if (empty) begin
						front_n = cmd_ch.push_byte;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					err_n = 1'b1;
				end else begin
					popped_n = front_q;
					head_n   = head_inc;
					count_n  = count_q - CW'(1);
					// The new front comes out of memory when anything remains.
					rd_en      = (count_q != CW'(1));
					rd_addr    = head_inc;
					rd_front_n = (count_q != CW'(1));
				end
			end
			CMD_POP_REAR: begin
				if (empty) begin
					err_n = 1'b1;
				end else begin
					popped_n  = rear_q;
					tail_n    = tail_dec;
					count_n   = count_q - CW'(1);
					rd_en     = (count_q != CW'(1));
					rd_addr   = tail_dec2;
					rd_rear_n = (count_q != CW'(1));
				end
			end
			default: begin
				err_n = 1'b1;
			end
		endcase
	end

	dq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd_ch.push_byte),
		.rd_en   (accept && rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Ends after the command in stage 1, with the fetched byte merged in.
	assign front_fin = rd_front_s1 ? rd_data : front_q;
	assign rear_fin  = rd_rear_s1  ? rd_data : rear_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			busy_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers. The end bytes are only looked at while the count is
	// nonzero, so they need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q     <= front_n;
			rear_q      <= rear_n;
			popped_s1   <= popped_n;
			err_s1      <= err_n;
			rd_front_s1 <= rd_front_n;
			rd_rear_s1  <= rd_rear_n;
		end else if (done) begin
			front_q <= front_fin;
			rear_q  <= rear_fin;
		end
		if (done) begin
			res_popped_q <= popped_s1;
			res_err_q    <= err_s1;
			res_count_q  <= count_q;
			res_empty_q  <= empty;
			res_front_q  <= empty ? '0 : front_fin;
			res_rear_q   <= empty ? '0 : rear_fin;
		end
	end

	assign res_ch.valid       = res_valid_q;
	assign res_ch.popped_byte = res_popped_q;
	assign res_ch.op_error    = res_err_q;
	assign res_ch.entry_count = res_count_q;
	assign res_ch.front_byte  = res_front_q;
	assign res_ch.rear_byte   = res_rear_q;
	assign res_ch.now_empty   = res_empty_q;
endmodule
